// File: sv/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg: shared types and constants of the retransmit slot table
// Operation and result codes, reset values of the configuration registers,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ars_pkg;

  // Default sizing of the table.
  localparam int SLOT_COUNT_DEF   = 8;
  localparam int NODE_ID_BITS_DEF = 16;

  // Most timeout events one tick can report.
  localparam logic [3:0] MAX_EVENTS = 4'd8;

  // Configuration register indexes and reset values.
  localparam int         CFG_INDEX_W       = 8;
  localparam logic [7:0] CFG_ACK_TIMEOUT   = 8'd0;
  localparam logic [7:0] CFG_MAX_RETRIES   = 8'd1;
  localparam logic [31:0] ACK_TIMEOUT_RESET = 32'd1000;
  localparam logic [7:0]  MAX_RETRIES_RESET = 8'd3;

  // Input operations.
  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ACK    = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_BEGUN       = 3'd0,
    KIND_TABLE_FULL  = 3'd1,
    KIND_CANCEL_DONE = 3'd2,
    KIND_ACK_MATCH   = 3'd3,
    KIND_ACK_MISS    = 3'd4,
    KIND_RETRY       = 3'd5,
    KIND_FAILED      = 3'd6,
    KIND_TICK_IDLE   = 3'd7
  } kind_t;

  // One result item, without the last flag.
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  slot;
    logic [15:0] src;
    logic [15:0] seq;
    logic [15:0] hop;
    logic [7:0]  attempt;
    logic [31:0] latency;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transaction
    logic rd_en;   // read the slot memory at the read index
    logic take;    // the evaluated slot produces an event
    logic cancel;  // free the selected slot
    logic flush;   // deliver the final result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t        op;     // operation of the item in progress
    logic [3:0] limit;  // event limit of the item, clamped
    logic       qual;   // the evaluated slot matches the operation
  } dp_status_t;

endpackage : ars_pkg

`default_nettype wire

// File: sv/ars_ctrl.sv
// ----------------------------------------------------------------------------
// ars_ctrl: sequencer of the retransmit slot table
// Walks the slots one per cycle with a one-stage read pipeline, counts the
// events of a tick and decides when an item is finished.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_ctrl #(
  parameter int SLOT_COUNT = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire  [1:0]               op,
  input  ars_pkg::dp_status_t      st,
  output ars_pkg::ctrl_cmd_t       cmd,
  output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_idx,
  output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] eval_idx,
  output logic                     busy
);
  import ars_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CANCEL,
    S_FLUSH
  } state_t;

  state_t       state;
  logic [CNT_W-1:0] rd_cnt;
  logic         eval_valid;
  logic [3:0]   ev_cnt;

  logic         issue;
  logic [3:0]   lim_eff;
  logic         take;
  logic         hit_lim;
  logic         end_scan;
  logic         done;

  // Scan bookkeeping: reads run one slot ahead of the evaluation.
  always_comb begin
    issue    = (rd_cnt < CNT_W'(SLOT_COUNT));
    lim_eff  = (st.op == OP_TICK) ? st.limit : 4'd1;
    take     = eval_valid && st.qual && (ev_cnt < lim_eff);
    hit_lim  = (4'(ev_cnt + 4'd1) == lim_eff);
    end_scan = eval_valid && (eval_idx == IDX_W'(SLOT_COUNT - 1));
    done     = (take && hit_lim) || end_scan;
    rd_idx   = rd_cnt[IDX_W-1:0];
  end

  // Commands decoded from the state.
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && start;
    cmd.rd_en  = (state == S_SCAN) && issue;
    cmd.take   = (state == S_SCAN) && take;
    cmd.cancel = (state == S_CANCEL);
    cmd.flush  = (state == S_FLUSH);
    busy       = (state != S_IDLE);
  end

  // State and scan counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_cnt     <= '0;
      eval_valid <= 1'b0;
      eval_idx   <= '0;
      ev_cnt     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rd_cnt     <= '0;
          eval_valid <= 1'b0;
          ev_cnt     <= '0;
          if (start) begin
            state <= (op_t'(op) == OP_CANCEL) ? S_CANCEL : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_cnt <= CNT_W'(rd_cnt + 1'b1);
          end
          eval_valid <= issue && !done;
          eval_idx   <= rd_idx;
          if (take) begin
            ev_cnt <= 4'(ev_cnt + 4'd1);
          end
          if (done) begin
            state <= S_FLUSH;
          end
        end
        S_CANCEL: begin
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : ars_ctrl

`default_nettype wire

// File: sv/ars_dp.sv
// ----------------------------------------------------------------------------
// ars_dp: datapath of the retransmit slot table
// Holds the configuration, the slot memory and active bits, evaluates one
// slot per cycle and stages results so the final one carries the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_dp #(
  parameter int SLOT_COUNT   = 8,
  parameter int NODE_ID_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  // Input transaction.
  input  wire  [1:0]               op,
  input  wire  [15:0]              src_node,
  input  wire  [15:0]              seq_num,
  input  wire  [15:0]              hop_node,
  input  wire  [7:0]               slot_sel,
  input  wire  [31:0]              now_ms,
  input  wire  [3:0]               max_events,
  // Configuration writes.
  input  wire                      cfg_we,
  input  wire  [ars_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [31:0]              cfg_data,
  // Controller interface.
  input  ars_pkg::ctrl_cmd_t       cmd,
  input  wire  [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_idx,
  input  wire  [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] eval_idx,
  output ars_pkg::dp_status_t      st,
  // Results.
  output logic                     strobe,
  output logic [2:0]               kind,
  output logic [2:0]               slot_out,
  output logic [15:0]              src_out,
  output logic [15:0]              seq_out,
  output logic [15:0]              hop_out,
  output logic [7:0]               attempt_out,
  output logic [31:0]              latency_ms,
  output logic                     last
);
  import ars_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Configuration registers.
  logic [31:0] ack_timeout;
  logic [7:0]  max_retries;

  // Captured input transaction.
  op_t                     op_r;
  logic [NODE_ID_BITS-1:0] src_r;
  logic [15:0]             seq_r;
  logic [NODE_ID_BITS-1:0] hop_r;
  logic [7:0]              sel_r;
  logic [31:0]             now_r;
  logic [3:0]              limit_r;

  // Slot storage.
  logic [SLOT_COUNT-1:0]   active;
  logic [NODE_ID_BITS-1:0] mem_src  [SLOT_COUNT];
  logic [15:0]             mem_seq  [SLOT_COUNT];
  logic [NODE_ID_BITS-1:0] mem_hop  [SLOT_COUNT];
  logic [7:0]              mem_att  [SLOT_COUNT];
  logic [31:0]             mem_sent [SLOT_COUNT];
  logic [NODE_ID_BITS-1:0] src_q;
  logic [15:0]             seq_q;
  logic [NODE_ID_BITS-1:0] hop_q;
  logic [7:0]              att_q;
  logic [31:0]             sent_q;

  // Result staging.
  result_t pend;
  logic    pend_valid;

  // Evaluation of the slot in the second pipeline stage.
  logic    eval_active;
  logic [31:0] age;
  logic [7:0]  retries_done;
  logic [7:0]  att_inc;
  logic    retry_ok;
  logic    qual;
  logic    wr_id;
  logic    wr_timer;
  result_t ev_res;
  result_t none_res;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RESET;
      max_retries <= MAX_RETRIES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ACK_TIMEOUT) begin
        ack_timeout <= cfg_data;
      end else if (cfg_index == CFG_MAX_RETRIES) begin
        max_retries <= cfg_data[7:0];
      end
    end
  end

  // Capture of the input transaction, with the event limit clamped.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(op);
      src_r   <= NODE_ID_BITS'(src_node);
      seq_r   <= seq_num;
      hop_r   <= NODE_ID_BITS'(hop_node);
      sel_r   <= slot_sel;
      now_r   <= now_ms;
      limit_r <= (max_events > MAX_EVENTS) ? MAX_EVENTS : max_events;
    end
  end

  // Slot evaluation against the current operation.
  always_comb begin
    eval_active  = active[eval_idx];
    age          = now_r - sent_q;
    retries_done = att_q - 8'd1;
    att_inc      = att_q + 8'd1;
    retry_ok     = (retries_done < max_retries);
    case (op_r)
      OP_BEGIN: qual = !eval_active;
      OP_ACK:   qual = eval_active && (src_q == src_r) && (seq_q == seq_r);
      OP_TICK:  qual = eval_active && (age >= ack_timeout);
      default:  qual = 1'b0;
    endcase
    st.op    = op_r;
    st.limit = limit_r;
    st.qual  = qual;

    wr_id    = cmd.take && (op_r == OP_BEGIN);
    wr_timer = cmd.take && ((op_r == OP_BEGIN) || ((op_r == OP_TICK) && retry_ok));

    // Result of the evaluated slot.
    ev_res = '0;
    case (op_r)
      OP_BEGIN: begin
        ev_res.kind = KIND_BEGUN;
        ev_res.slot = 3'(eval_idx);
      end
      OP_ACK: begin
        ev_res.kind    = KIND_ACK_MATCH;
        ev_res.hop     = 16'(hop_q);
        ev_res.latency = age;
      end
      default: begin
        ev_res.kind    = retry_ok ? KIND_RETRY : KIND_FAILED;
        ev_res.slot    = 3'(eval_idx);
        ev_res.src     = 16'(src_q);
        ev_res.seq     = seq_q;
        ev_res.hop     = 16'(hop_q);
        ev_res.attempt = retry_ok ? att_inc : att_q;
      end
    endcase

    // Result of an item that found nothing.
    none_res = '0;
    case (op_r)
      OP_BEGIN:  none_res.kind = KIND_TABLE_FULL;
      OP_CANCEL: none_res.kind = KIND_CANCEL_DONE;
      OP_ACK:    none_res.kind = KIND_ACK_MISS;
      default:   none_res.kind = KIND_TICK_IDLE;
    endcase
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_id) begin
      mem_src[eval_idx] <= src_r;
      mem_seq[eval_idx] <= seq_r;
      mem_hop[eval_idx] <= hop_r;
    end
    if (wr_timer) begin
      mem_att[eval_idx]  <= (op_r == OP_BEGIN) ? 8'd1 : att_inc;
      mem_sent[eval_idx] <= now_r;
    end
    if (cmd.rd_en) begin
      src_q  <= mem_src[rd_idx];
      seq_q  <= mem_seq[rd_idx];
      hop_q  <= mem_hop[rd_idx];
      att_q  <= mem_att[rd_idx];
      sent_q <= mem_sent[rd_idx];
    end
  end

  // Active bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.take) begin
      if (op_r == OP_BEGIN) begin
        active[eval_idx] <= 1'b1;
      end else if ((op_r == OP_ACK) || !retry_ok) begin
        active[eval_idx] <= 1'b0;
      end
    end else if (cmd.cancel && ({1'b0, sel_r} < 9'(SLOT_COUNT))) begin
      active[sel_r[IDX_W-1:0]] <= 1'b0;
    end
  end

  // Result staging: an event waits until the next one or the end of the
  // item shows whether it is the final result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.take) begin
        if (pend_valid) begin
          strobe      <= 1'b1;
          kind        <= pend.kind;
          slot_out    <= pend.slot;
          src_out     <= pend.src;
          seq_out     <= pend.seq;
          hop_out     <= pend.hop;
          attempt_out <= pend.attempt;
          latency_ms  <= pend.latency;
          last        <= 1'b0;
        end
        pend       <= ev_res;
        pend_valid <= 1'b1;
      end else if (cmd.cancel) begin
        pend       <= none_res;
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        strobe      <= 1'b1;
        kind        <= pend_valid ? pend.kind    : none_res.kind;
        slot_out    <= pend_valid ? pend.slot    : none_res.slot;
        src_out     <= pend_valid ? pend.src     : none_res.src;
        seq_out     <= pend_valid ? pend.seq     : none_res.seq;
        hop_out     <= pend_valid ? pend.hop     : none_res.hop;
        attempt_out <= pend_valid ? pend.attempt : none_res.attempt;
        latency_ms  <= pend_valid ? pend.latency : none_res.latency;
        last        <= 1'b1;
        pend_valid  <= 1'b0;
      end
    end
  end

endmodule : ars_dp

`default_nettype wire

// File: sv/ack_retransmit_slot_table.sv
// ----------------------------------------------------------------------------
// ack_retransmit_slot_table: table of pending transmissions awaiting ack
// Begin, cancel, ack and timeout tick operations over SLOT_COUNT slots.
// ----------------------------------------------------------------------------
// Usage:
// An operation is a transaction on start/busy: it is taken at a rising edge
// with start high and busy low, and busy stays high until its final result
// has been shown. Begin, ack and tick walk the slots in ascending order, one
// slot per cycle through the registered read port of the slot memory, with
// the read one slot ahead of the evaluation. A begin or ack stops at the
// first hit, a tick at its event limit.
// The final result ends the operation: busy drops with it, and a new start
// is not taken before then, so operations never overlap.
// Results are shown for exactly one cycle on strobe and the receiver cannot
// stall them; the final result of each operation has last set.
// Configuration writes on cfg_valid/cfg_ready are always taken (cfg_ready is
// tied high) and belong between operations.
// Reset clears all slots to free, restores the register defaults and drops
// any operation in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_retransmit_slot_table #(
  parameter int SLOT_COUNT   = ars_pkg::SLOT_COUNT_DEF,
  parameter int NODE_ID_BITS = ars_pkg::NODE_ID_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // Operation channel.
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  op,
  input  wire  [15:0] src_node,
  input  wire  [15:0] seq_num,
  input  wire  [15:0] hop_node,
  input  wire  [7:0]  slot_sel,
  input  wire  [31:0] now_ms,
  input  wire  [3:0]  max_events,
  // Configuration channel.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [ars_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [31:0] cfg_data,
  // Result channel.
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [2:0]  slot_out,
  output logic [15:0] src_out,
  output logic [15:0] seq_out,
  output logic [15:0] hop_out,
  output logic [7:0]  attempt_out,
  output logic [31:0] latency_ms,
  output logic        last
);
  import ars_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  ctrl_cmd_t   cmd;
  dp_status_t  st;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] eval_idx;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  ars_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .st       (st),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .eval_idx (eval_idx),
    .busy     (busy)
  );

  // Storage and evaluation.
  ars_dp #(
    .SLOT_COUNT   (SLOT_COUNT),
    .NODE_ID_BITS (NODE_ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .src_node    (src_node),
    .seq_num     (seq_num),
    .hop_node    (hop_node),
    .slot_sel    (slot_sel),
    .now_ms      (now_ms),
    .max_events  (max_events),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .eval_idx    (eval_idx),
    .st          (st),
    .strobe      (strobe),
    .kind        (kind),
    .slot_out    (slot_out),
    .src_out     (src_out),
    .seq_out     (seq_out),
    .hop_out     (hop_out),
    .attempt_out (attempt_out),
    .latency_ms  (latency_ms),
    .last        (last)
  );

endmodule : ack_retransmit_slot_table

`default_nettype wire

// File: sv/ars_checker.sv
// ----------------------------------------------------------------------------
// ars_checker: port-level checks of the retransmit slot table
// Relates the operation handshake to the result strobe and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        strobe,
  input wire [2:0]  kind,
  input wire        last
);
  import ars_pkg::*;

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted operation did not raise busy");

  // The final result coincides with the block being free again.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final result shown while still busy");

  // An intermediate result always has more results to follow.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("intermediate result with the block idle");

  // Only timeout events can be followed by further results.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind != KIND_RETRY) && (kind != KIND_FAILED)) |-> last)
    else $error("single-result kind without last flag");

endmodule : ars_checker

bind ack_retransmit_slot_table ars_checker u_ars_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .kind   (kind),
  .last   (last)
);

`default_nettype wire

// File: tb/ack_retransmit_slot_table_test.sv
// ----------------------------------------------------------------------------
// ack_retransmit_slot_table_test: self-checking bench of the retransmit table
// Drives begin, cancel, ack and tick transactions in random bursts, predicts
// every result from a local copy of the slot table and its registers, and
// compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module ack_retransmit_slot_table_test;
  import ars_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HALF_PERIOD  = 5;
  localparam int          RESET_CYCLES = 6;
  localparam int          SLOTS        = SLOT_COUNT_DEF;
  localparam int          SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          PRINT_LIMIT  = 200;
  localparam logic [31:0] BASE_MS      = 32'hFFFF_FF00;
  localparam logic [7:0]  CFG_UNUSED_LOW = 8'd2;
  localparam logic [7:0]  CFG_UNUSED_TOP = 8'd255;

  // One operation as presented on the input ports.
  typedef struct packed {
    op_t         op;
    logic [15:0] src;
    logic [15:0] seq;
    logic [15:0] hop;
    logic [7:0]  sel;
    logic [31:0] now;
    logic [3:0]  max_ev;
  } cmd_t;

  // One predicted result with its last flag.
  typedef struct packed {
    result_t res;
    logic    last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        start      = 1'b0;
  logic        busy;
  logic [1:0]  op         = '0;
  logic [15:0] src_node   = '0;
  logic [15:0] seq_num    = '0;
  logic [15:0] hop_node   = '0;
  logic [7:0]  slot_sel   = '0;
  logic [31:0] now_ms     = '0;
  logic [3:0]  max_events = '0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data  = '0;

  logic        strobe;
  logic [2:0]  kind;
  logic [2:0]  slot_out;
  logic [15:0] src_out;
  logic [15:0] seq_out;
  logic [15:0] hop_out;
  logic [7:0]  attempt_out;
  logic [31:0] latency_ms;
  logic        last;

  // Local copy of the table and its registers.
  logic        slot_live [SLOTS] = '{default: 1'b0};
  logic [15:0] slot_src [SLOTS];
  logic [15:0] slot_seq [SLOTS];
  logic [15:0] slot_hop [SLOTS];
  logic [7:0]  slot_tries [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [31:0] timeout_reg = ACK_TIMEOUT_RESET;
  logic [7:0]  retry_reg   = MAX_RETRIES_RESET;

  cmd_t        pending_cmds [$];
  outcome_t    awaited_results [$];
  logic [31:0] key_pool [$];
  cmd_t        cur_cmd;
  logic [31:0] sim_ms = '0;
  logic        took_item = 1'b0;
  int          cmds_issued = 0;
  int          cmds_taken = 0;
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          quiet_cycles = 0;

  ack_retransmit_slot_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .src_node    (src_node),
    .seq_num     (seq_num),
    .hop_node    (hop_node),
    .slot_sel    (slot_sel),
    .now_ms      (now_ms),
    .max_events  (max_events),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .kind        (kind),
    .slot_out    (slot_out),
    .src_out     (src_out),
    .seq_out     (seq_out),
    .hop_out     (hop_out),
    .attempt_out (attempt_out),
    .latency_ms  (latency_ms),
    .last        (last)
  );

  // Clock generation.
  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  function automatic outcome_t make_result(input kind_t k, input logic [2:0] slot,
                                           input logic [15:0] src, input logic [15:0] seq,
                                           input logic [15:0] hop, input logic [7:0] att,
                                           input logic [31:0] lat, input logic fin);
    outcome_t o;
    o.res.kind    = k;
    o.res.slot    = slot;
    o.res.src     = src;
    o.res.seq     = seq;
    o.res.hop     = hop;
    o.res.attempt = att;
    o.res.latency = lat;
    o.last        = fin;
    return o;
  endfunction

  // Apply one accepted operation to the local table and queue its results.
  function automatic void predict_outcomes(input cmd_t c);
    logic [3:0] cap;
    logic [7:0] tries_used;
    int         events;
    bit         found;
    bit         held_valid;
    outcome_t   held;
    found      = 1'b0;
    held_valid = 1'b0;
    events     = 0;
    case (c.op)
      OP_BEGIN: begin
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (!slot_live[i]) begin
            slot_live[i]  = 1'b1;
            slot_src[i]   = c.src;
            slot_seq[i]   = c.seq;
            slot_hop[i]   = c.hop;
            slot_tries[i] = 8'd1;
            slot_stamp[i] = c.now;
            awaited_results.push_back(make_result(KIND_BEGUN, 3'(i), '0, '0, '0, '0, '0, 1'b1));
            found = 1'b1;
          end
        end
        if (!found) begin
          awaited_results.push_back(make_result(KIND_TABLE_FULL, '0, '0, '0, '0, '0, '0, 1'b1));
        end
      end
      OP_CANCEL: begin
        // Out-of-range or free slots change nothing but still report completion.
        if (c.sel < SLOTS) begin
          slot_live[c.sel[SLOT_W-1:0]] = 1'b0;
        end
        awaited_results.push_back(make_result(KIND_CANCEL_DONE, '0, '0, '0, '0, '0, '0, 1'b1));
      end
      OP_ACK: begin
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (slot_live[i] && slot_src[i] == c.src && slot_seq[i] == c.seq) begin
            slot_live[i] = 1'b0;
            awaited_results.push_back(make_result(KIND_ACK_MATCH, '0, '0, '0, slot_hop[i], '0,
                                                  c.now - slot_stamp[i], 1'b1));
            found = 1'b1;
          end
        end
        if (!found) begin
          awaited_results.push_back(make_result(KIND_ACK_MISS, '0, '0, '0, '0, '0, '0, 1'b1));
        end
      end
      default: begin
        // Timeout scan; the last event is held back so it can carry the last flag.
        cap = (c.max_ev > MAX_EVENTS) ? MAX_EVENTS : c.max_ev;
        for (int i = 0; i < SLOTS && events < cap; i++) begin
          if (slot_live[i] && (c.now - slot_stamp[i]) >= timeout_reg) begin
            if (held_valid) begin
              awaited_results.push_back(held);
            end
            tries_used = slot_tries[i] - 8'd1;
            if (tries_used < retry_reg) begin
              slot_tries[i] = slot_tries[i] + 8'd1;
              slot_stamp[i] = c.now;
              held = make_result(KIND_RETRY, 3'(i), slot_src[i], slot_seq[i], slot_hop[i],
                                 slot_tries[i], '0, 1'b0);
            end else begin
              slot_live[i] = 1'b0;
              held = make_result(KIND_FAILED, 3'(i), slot_src[i], slot_seq[i], slot_hop[i],
                                 slot_tries[i], '0, 1'b0);
            end
            held_valid = 1'b1;
            events++;
          end
        end
        if (held_valid) begin
          held.last = 1'b1;
          awaited_results.push_back(held);
        end else begin
          awaited_results.push_back(make_result(KIND_TICK_IDLE, '0, '0, '0, '0, '0, '0, 1'b1));
        end
      end
    endcase
  endfunction

  // Printing stops after a while so a broken block cannot flood the log.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, wanted));
    end
  endtask

  task automatic issue(input op_t op_code, input logic [15:0] src, input logic [15:0] seq,
                       input logic [15:0] hop, input logic [7:0] sel, input logic [31:0] now,
                       input logic [3:0] max_ev);
    pending_cmds.push_back('{op_code, src, seq, hop, sel, now, max_ev});
    cmds_issued++;
  endtask

  // Mostly coherent traffic on an advancing clock: acks of keys begun earlier,
  // cancels of real slots, ticks with useful limits; the rest is noise.
  task automatic queue_random(input int unsigned count, input int unsigned step);
    int unsigned pick;
    logic [31:0] key;
    op_t         op_code;
    logic [15:0] src;
    logic [15:0] seq;
    logic [7:0]  sel;
    logic [3:0]  max_ev;
    logic [31:0] now;
    for (int unsigned n = 0; n < count; n++) begin
      pick   = $urandom_range(0, 99);
      key    = $urandom;
      sel    = 8'($urandom);
      max_ev = 4'($urandom);
      sim_ms = sim_ms + $urandom_range(0, step);
      now    = ($urandom_range(0, 19) == 0) ? $urandom : sim_ms;
      if (key_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
        if (pick < 35 && $urandom_range(0, 7) != 0) begin
          key = key;
        end else begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
      end
      if (pick < 35) begin
        op_code = OP_BEGIN;
        key_pool.push_back(key);
        if (key_pool.size() > 12) begin
          void'(key_pool.pop_front());
        end
      end else if (pick < 60) begin
        op_code = OP_ACK;
      end else if (pick < 90) begin
        op_code = OP_TICK;
        if ($urandom_range(0, 3) != 0) begin
          max_ev = 4'($urandom_range(1, 8));
        end
      end else begin
        op_code = OP_CANCEL;
        if ($urandom_range(0, 4) != 0) begin
          sel = 8'($urandom_range(0, SLOTS - 1));
        end
      end
      src = key[31:16];
      seq = key[15:0];
      issue(op_code, src, seq, 16'($urandom), sel, now, max_ev);
    end
  endtask

  // Register write on the configuration channel; the local copy follows it.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_ACK_TIMEOUT) begin
      timeout_reg = val;
    end else if (idx == CFG_MAX_RETRIES) begin
      retry_reg = val[7:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every operation is taken and answered, then let the block go idle.
  task automatic settle();
    do @(negedge clk); while (cmds_taken != cmds_issued || awaited_results.size() != 0);
    repeat (SLOTS + 4) @(negedge clk);
  endtask

  // Driver: presents queued operations in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (took_item) begin
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        op         <= cur_cmd.op;
        src_node   <= cur_cmd.src;
        seq_num    <= cur_cmd.seq;
        hop_node   <= cur_cmd.hop;
        slot_sel   <= cur_cmd.sel;
        now_ms     <= cur_cmd.now;
        max_events <= cur_cmd.max_ev;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks strobed results, then predicts for a newly taken operation.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      took_item <= 1'b0;
    end else begin
      if (strobe) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d with none expected", kind));
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", kind, want.res.kind);
          check_field("slot_out", slot_out, want.res.slot);
          check_field("src_out", src_out, want.res.src);
          check_field("seq_out", seq_out, want.res.seq);
          check_field("hop_out", hop_out, want.res.hop);
          check_field("attempt_out", attempt_out, want.res.attempt);
          check_field("latency_ms", latency_ms, want.res.latency);
          check_field("last", last, want.last);
        end
      end
      if (start && !busy) begin
        predict_outcomes(cur_cmd);
        cmds_taken++;
      end
      took_item <= start && !busy;
    end
  end

  // Watchdog: any transaction or result counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned span;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed part with reset register values: empty tick, fill the table past
    // capacity, acks across the time wrap and on a duplicate key, cancels of a
    // taken, a free and out-of-range slots, then ticks until every entry fails.
    issue(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h0, 4'd0);
    issue(OP_BEGIN, 16'h0000, 16'h0000, 16'h0000, 8'h00, BASE_MS, 4'd0);
    issue(OP_BEGIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, BASE_MS, 4'hF);
    for (int n = 2; n < SLOTS - 1; n++) begin
      issue(OP_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), BASE_MS,
            4'($urandom));
    end
    issue(OP_BEGIN, 16'h0000, 16'h0000, 16'h1234, 8'h00, BASE_MS + 1, 4'd0);
    issue(OP_BEGIN, 16'h1111, 16'h2222, 16'h3333, 8'h00, 32'd5, 4'd0);
    issue(OP_ACK, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 32'h100, 4'd0);
    issue(OP_ACK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h200, 4'd0);
    issue(OP_ACK, 16'h5A5A, 16'hA5A5, 16'h0000, 8'h00, 32'h0, 4'd0);
    issue(OP_CANCEL, 16'h0000, 16'h0000, 16'h0000, 8'd3, 32'h0, 4'd0);
    issue(OP_CANCEL, 16'h0000, 16'h0000, 16'h0000, 8'd3, 32'h0, 4'd0);
    issue(OP_CANCEL, 16'h0000, 16'h0000, 16'h0000, 8'd8, 32'h0, 4'd0);
    issue(OP_CANCEL, 16'h0000, 16'h0000, 16'h0000, 8'd255, 32'h0, 4'd0);
    issue(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h300, 4'd0);
    issue(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h300, 4'd2);
    issue(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h300, 4'hF);
    for (int n = 1; n <= 4; n++) begin
      issue(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h300 + n * 1000, 4'd8);
    end
    settle();

    // Immediate timeout and no retries: each tick fails whatever it reaches.
    write_reg(CFG_ACK_TIMEOUT, 32'h0);
    write_reg(CFG_MAX_RETRIES, 32'h0);
    queue_random(10, 50);
    settle();

    // Longest timeout: only an age of all ones expires.
    write_reg(CFG_ACK_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_RETRIES, 32'd254);
    for (int n = 0; n < SLOTS; n++) begin
      issue(OP_CANCEL, 16'($urandom), 16'($urandom), 16'($urandom), 8'(n), $urandom,
            4'($urandom));
    end
    issue(OP_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom), 8'h00, 32'd5, 4'd0);
    issue(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'd4, 4'd8);
    queue_random(8, 1000);
    settle();

    // Moderate timeout with a few retries, clock steps near the timeout.
    span = $urandom_range(20, 400);
    write_reg(CFG_ACK_TIMEOUT, span);
    write_reg(CFG_MAX_RETRIES, $urandom_range(1, 6));
    queue_random(20, span / 3 + 1);
    settle();

    // Unused indexes are ignored and upper data bits of the retry limit dropped.
    write_reg(CFG_UNUSED_LOW, $urandom);
    write_reg(CFG_UNUSED_TOP, 32'hFFFF_FFFF);
    write_reg(CFG_ACK_TIMEOUT, ACK_TIMEOUT_RESET);
    write_reg(CFG_MAX_RETRIES, {24'hABCDEF, MAX_RETRIES_RESET});
    queue_random(10, 400);
    settle();

    // A retry limit of 255 lets the attempt count wrap to zero before failing;
    // the lowest live entry takes an event on every tick.
    write_reg(CFG_ACK_TIMEOUT, 32'h0);
    write_reg(CFG_MAX_RETRIES, 32'hFFFF_FFFF);
    issue(OP_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
          4'($urandom));
    issue(OP_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
          4'($urandom));
    for (int n = 0; n < 256; n++) begin
      issue(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
            4'($urandom_range(2, 15)));
    end
    settle();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
